// ----- hw/rtl/dgs_pkg.sv -----
// Shared types, widths and codes of the dot grid symbol op generator.
package dgs_pkg;

	localparam int CANVAS_W = 12;
	localparam int PAT_W = 36;
	localparam int RAD_W = 10;
	localparam int COLOR_W = 24;
	localparam int KIND_W = 2;
	localparam int SIDE_W = 11;
	localparam int REM_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int GRID_SIDE_DEF = 6;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [KIND_W-1:0] OP_RECT = 2'd0;
	localparam logic [KIND_W-1:0] OP_CIRCLE = 2'd1;
	localparam logic [KIND_W-1:0] OP_DOT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DOT_COLOR = 2'd2;

	typedef struct packed {
		logic [CANVAS_W-1:0] width;
		logic [CANVAS_W-1:0] height;
		logic [PAT_W-1:0] pattern;
	} dgs_geom_t;

	typedef struct packed {
		logic [CANVAS_W-1:0] width;
		logic [CANVAS_W-1:0] height;
		logic [CANVAS_W-1:0] cx;
		logic [CANVAS_W-1:0] cy;
		logic [RAD_W-1:0] radius;
		logic [SIDE_W-1:0] step_q;
		logic [REM_W-1:0] step_r;
		logic [RAD_W-1:0] dot_r;
		logic [CANVAS_W-1:0] base_x;
		logic [CANVAS_W-1:0] base_y;
		logic [PAT_W-1:0] pattern;
	} dgs_desc_t;

	typedef struct packed {
		logic [COLOR_W-1:0] background;
		logic [COLOR_W-1:0] foreground;
		logic [COLOR_W-1:0] dot;
	} dgs_colors_t;

	typedef struct packed {
		logic valid;
		logic [KIND_W-1:0] kind;
		logic [CANVAS_W-1:0] pos_x;
		logic [CANVAS_W-1:0] pos_y;
		logic [CANVAS_W-1:0] rect_w;
		logic [CANVAS_W-1:0] rect_h;
		logic [RAD_W-1:0] radius;
		logic [COLOR_W-1:0] color;
		logic last;
	} dgs_op_t;

	typedef struct packed {
		logic empty;
		logic full;
	} dgs_qstat_t;

endpackage

// ----- hw/rtl/dgs_front.sv -----
// Front pipeline: derives circle, square and dot geometry of one request.
module dgs_front import dgs_pkg::*; #(
	parameter int GRID_SIDE = GRID_SIDE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [CANVAS_W-1:0] in_width,
	input  logic [CANVAS_W-1:0] in_height,
	input  logic [PAT_W-1:0] in_pattern,
	output logic push,
	output dgs_desc_t desc
);

	// Keep only the pattern bits the grid uses.
	localparam logic [PAT_W-1:0] PAT_MASK = {PAT_W{1'b1}} << (PAT_W - GRID_SIDE * GRID_SIDE);
	// Reciprocal of the grid side, scaled by 2^16 and rounded down.
	localparam int GRID_RECIP = 65536 / GRID_SIDE;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	dgs_geom_t g_s1, g_s2, g_s3, g_s4, g_s5, g_s6;
	logic [20:0] p_s1, p_s2;
	logic [SIDE_W-1:0] q0_s2;
	logic [SIDE_W-1:0] s_s3, s_s4, s_s5, s_s6;
	logic [SIDE_W-1:0] gq0_s4;
	logic [SIDE_W-1:0] gq_s5;
	logic [REM_W-1:0] gr_s5, gr_s6;
	logic [SIDE_W-1:0] gq_s6;
	logic [6:0] c10_s6;

	logic [31:0] prod2;
	logic [20:0] m3, diff3;
	logic [SIDE_W-1:0] s3;
	logic [27:0] prod4;
	logic [SIDE_W-1:0] t5, gq5;
	logic [REM_W-1:0] gr5;
	logic [RAD_W-1:0] d0_6, plus9;
	logic [17:0] prod6;
	logic [RAD_W-1:0] d0_q, dot_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// radius * 1414, then divide by 1000 through a reciprocal with one correction
	assign prod2 = 32'(p_s1) * 32'd1048;
	assign m3 = 21'(q0_s2) * 21'd1000;
	assign diff3 = p_s2 - m3;
	assign s3 = (diff3 >= 21'd1000) ? q0_s2 + 11'd1 : q0_s2;

	// side / GRID_SIDE with remainder, same scheme
	assign prod4 = 28'(s_s3) * 28'(GRID_RECIP);
	assign t5 = s_s4 - 11'(gq0_s4 * 11'(GRID_SIDE));
	always_comb begin
		if (t5 >= 11'(GRID_SIDE)) begin
			gq5 = gq0_s4 + 11'd1;
			gr5 = 3'(t5 - 11'(GRID_SIDE));
		end else begin
			gq5 = gq0_s4;
			gr5 = 3'(t5);
		end
	end

	// dot radius: floor(side / 2G), less its tenth rounded up
	assign d0_6 = gq_s5[SIDE_W-1:1];
	assign plus9 = d0_6 + 10'd9;
	assign prod6 = 18'(plus9) * 18'd205;

	always_ff @(posedge clk) begin
		g_s1 <= '{width: in_width, height: in_height, pattern: in_pattern & PAT_MASK};
		p_s1 <= 21'(in_width[CANVAS_W-1:2]) * 21'd1414;
		g_s2 <= g_s1;
		p_s2 <= p_s1;
		q0_s2 <= prod2[30:20];
		g_s3 <= g_s2;
		s_s3 <= s3;
		g_s4 <= g_s3;
		s_s4 <= s_s3;
		gq0_s4 <= prod4[26:16];
		g_s5 <= g_s4;
		s_s5 <= s_s4;
		gq_s5 <= gq5;
		gr_s5 <= gr5;
		g_s6 <= g_s5;
		s_s6 <= s_s5;
		gq_s6 <= gq_s5;
		gr_s6 <= gr_s5;
		c10_s6 <= prod6[17:11];
	end

	assign d0_q = gq_s6[SIDE_W-1:1];
	assign dot_r = d0_q - 10'(c10_s6);

	always_comb begin
		desc.width = g_s6.width;
		desc.height = g_s6.height;
		desc.cx = {1'b0, g_s6.width[CANVAS_W-1:1]};
		desc.cy = {1'b0, g_s6.height[CANVAS_W-1:1]};
		desc.radius = g_s6.width[CANVAS_W-1:2];
		desc.step_q = gq_s6;
		desc.step_r = gr_s6;
		desc.dot_r = dot_r;
		desc.base_x = {1'b0, g_s6.width[CANVAS_W-1:1]} - 12'(s_s6[SIDE_W-1:1]) + 12'(dot_r);
		desc.base_y = {1'b0, g_s6.height[CANVAS_W-1:1]} - 12'(s_s6[SIDE_W-1:1]) + 12'(dot_r);
		desc.pattern = g_s6.pattern;
	end

	assign push = v_s6;

endmodule

// ----- hw/rtl/dgs_queue.sv -----
// Short descriptor queue between the front pipeline and the op sequencer.
module dgs_queue import dgs_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  dgs_desc_t wr_desc,
	input  logic pop,
	output dgs_desc_t rd_desc,
	output dgs_qstat_t stat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	dgs_desc_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign rd_desc = mem_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full = (count_q == CNT_W'(QUEUE_DEPTH));

endmodule

// ----- hw/rtl/dgs_back.sv -----
// Op sequencer: walks one descriptor and emits its drawing ops; it loads the next one as it ends the last.
module dgs_back import dgs_pkg::*; #(
	parameter int GRID_SIDE = GRID_SIDE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  dgs_desc_t desc,
	input  logic q_empty,
	input  dgs_colors_t colors,
	output logic pop,
	output dgs_op_t op
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_BG   = 5'b00010,
		ST_CIRC = 5'b00100,
		ST_SQ   = 5'b01000,
		ST_DOTS = 5'b10000
	} dgs_state_t;

	dgs_state_t state_q;
	dgs_desc_t cur_q;
	logic [PAT_W-1:0] pat_q;
	logic [2:0] col_q;
	logic [SIDE_W-1:0] xq_q, yq_q;
	logic [REM_W-1:0] xr_q, yr_q;
	dgs_op_t op_q;

	logic finish;
	logic rest_zero;
	logic [REM_W:0] xsum, ysum;

	assign rest_zero = (pat_q[PAT_W-2:0] == '0);
	assign finish = ((state_q == ST_SQ) && (pat_q == '0)) || ((state_q == ST_DOTS) && rest_zero);
	assign pop = !q_empty && ((state_q == ST_IDLE) || finish);

	assign xsum = {1'b0, xr_q} + {1'b0, cur_q.step_r};
	assign ysum = {1'b0, yr_q} + {1'b0, cur_q.step_r};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			if (pop) begin
				state_q <= ST_BG;
			end else begin
				unique case (state_q)
					ST_IDLE: state_q <= ST_IDLE;
					ST_BG:   state_q <= ST_CIRC;
					ST_CIRC: state_q <= ST_SQ;
					ST_SQ:   state_q <= finish ? ST_IDLE : ST_DOTS;
					ST_DOTS: state_q <= finish ? ST_IDLE : ST_DOTS;
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// Load a fresh descriptor on pop, advance the grid walk in the dot phase.
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= desc;
			pat_q <= desc.pattern;
			col_q <= '0;
			xq_q <= '0;
			xr_q <= '0;
			yq_q <= '0;
			yr_q <= '0;
		end else if (state_q == ST_DOTS) begin
			pat_q <= {pat_q[PAT_W-2:0], 1'b0};
			if (col_q == 3'(GRID_SIDE - 1)) begin
				col_q <= '0;
				xq_q <= '0;
				xr_q <= '0;
				if (ysum >= 4'(GRID_SIDE)) begin
					yr_q <= 3'(ysum - 4'(GRID_SIDE));
					yq_q <= yq_q + cur_q.step_q + 11'd1;
				end else begin
					yr_q <= 3'(ysum);
					yq_q <= yq_q + cur_q.step_q;
				end
			end else begin
				col_q <= col_q + 3'd1;
				if (xsum >= 4'(GRID_SIDE)) begin
					xr_q <= 3'(xsum - 4'(GRID_SIDE));
					xq_q <= xq_q + cur_q.step_q + 11'd1;
				end else begin
					xr_q <= 3'(xsum);
					xq_q <= xq_q + cur_q.step_q;
				end
			end
		end
	end

	// Output register: strobe and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= '0;
		end else begin
			op_q.valid <= (state_q == ST_BG) || (state_q == ST_CIRC) || (state_q == ST_SQ) ||
				((state_q == ST_DOTS) && pat_q[PAT_W-1]);
			op_q.kind <= OP_RECT;
			op_q.pos_x <= cur_q.cx;
			op_q.pos_y <= cur_q.cy;
			op_q.rect_w <= '0;
			op_q.rect_h <= '0;
			op_q.radius <= '0;
			op_q.color <= colors.foreground;
			op_q.last <= 1'b0;
			unique case (state_q)
				ST_BG: begin
					op_q.pos_x <= '0;
					op_q.pos_y <= '0;
					op_q.rect_w <= cur_q.width;
					op_q.rect_h <= cur_q.height;
					op_q.color <= colors.background;
				end
				ST_CIRC: begin
					op_q.kind <= OP_CIRCLE;
					op_q.radius <= cur_q.radius;
				end
				ST_SQ: begin
					op_q.rect_w <= 12'(cur_q.radius);
					op_q.rect_h <= 12'(cur_q.radius);
					op_q.last <= (pat_q == '0);
				end
				ST_DOTS: begin
					op_q.kind <= OP_DOT;
					op_q.pos_x <= cur_q.base_x + 12'(xq_q);
					op_q.pos_y <= cur_q.base_y + 12'(yq_q);
					op_q.radius <= cur_q.dot_r;
					op_q.color <= colors.dot;
					op_q.last <= rest_zero;
				end
				ST_IDLE: begin
					op_q.last <= 1'b0;
				end
				default: begin
					op_q.last <= 1'b0;
				end
			endcase
		end
	end

	assign op = op_q;

endmodule

// ----- hw/rtl/dot_grid_symbol_op_generator_unit.sv -----
// Top level of the dot grid symbol op generator: config registers, credits, wiring.
//
//  channel   | handshake           | payload
//  ----------+---------------------+-------------------------------------------
//  request   | start / busy        | canvas_width, canvas_height, dot_pattern
//  config    | cfg_we              | cfg_index, cfg_data
//  result    | op_valid (strobe)   | op_kind, pos_x, pos_y, rect_width,
//            |                     | rect_height, shape_radius, op_color, last_op
//
// A request runs through a 6-stage front pipeline (radius*1414/1000, side/GRID_SIDE,
// dot radius), waits in a QUEUE_DEPTH-entry queue, and is then walked by the op
// sequencer at one cell per cycle, from the background, circle and square ops to the
// last set pattern bit of the grid. The sequencer sets the rate; it pops the next
// request in the cycle it ends the last. On an idle block the first strobe follows
// the front stages, the queue, the BG state and the output register.
// Reset clears valids, credits and the registers to their listed values; busy
// rises while QUEUE_DEPTH requests sit in the front pipeline or the queue.
module dot_grid_symbol_op_generator_unit import dgs_pkg::*; #(
	parameter int GRID_SIDE = GRID_SIDE_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [CANVAS_W-1:0] canvas_width,
	input  logic [CANVAS_W-1:0] canvas_height,
	input  logic [PAT_W-1:0] dot_pattern,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COLOR_W-1:0] cfg_data,
	output logic op_valid,
	output logic [KIND_W-1:0] op_kind,
	output logic [CANVAS_W-1:0] pos_x,
	output logic [CANVAS_W-1:0] pos_y,
	output logic [CANVAS_W-1:0] rect_width,
	output logic [CANVAS_W-1:0] rect_height,
	output logic [RAD_W-1:0] shape_radius,
	output logic [COLOR_W-1:0] op_color,
	output logic last_op
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	dgs_colors_t colors_q;
	logic [CNT_W-1:0] credit_q;
	logic accept;
	logic push, pop;
	dgs_desc_t front_desc, queue_desc;
	dgs_qstat_t qstat;
	dgs_op_t op;

	// Color registers; out-of-range indexes drop the write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colors_q.background <= 24'hFFFFFF;
			colors_q.foreground <= 24'h000000;
			colors_q.dot <= 24'hFFFFFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BACKGROUND: colors_q.background <= cfg_data;
				REG_FOREGROUND: colors_q.foreground <= cfg_data;
				REG_DOT_COLOR:  colors_q.dot <= cfg_data;
				default: ;
			endcase
		end
	end

	// Count requests in the front pipeline and queue; a slot frees on pop, so the
	// queue can never overflow even though the front pipeline has no stall.
	assign accept = start && !busy;
	assign busy = (credit_q == CNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (accept && !pop) begin
			credit_q <= credit_q + CNT_W'(1);
		end else if (pop && !accept) begin
			credit_q <= credit_q - CNT_W'(1);
		end
	end

	dgs_front #(.GRID_SIDE(GRID_SIDE)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(accept),
		.in_width(canvas_width),
		.in_height(canvas_height),
		.in_pattern(dot_pattern),
		.push(push),
		.desc(front_desc)
	);

	dgs_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_desc(front_desc),
		.pop(pop),
		.rd_desc(queue_desc),
		.stat(qstat)
	);

	dgs_back #(.GRID_SIDE(GRID_SIDE)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.desc(queue_desc),
		.q_empty(qstat.empty),
		.colors(colors_q),
		.pop(pop),
		.op(op)
	);

	assign op_valid = op.valid;
	assign op_kind = op.kind;
	assign pos_x = op.pos_x;
	assign pos_y = op.pos_y;
	assign rect_width = op.rect_w;
	assign rect_height = op.rect_h;
	assign shape_radius = op.radius;
	assign op_color = op.color;
	assign last_op = op.valid && op.last;

`ifndef SYNTHESIS
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= CNT_W'(QUEUE_DEPTH))
		else $error("request credit count above queue depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!qstat.full || pop))
		else $error("descriptor pushed into a full queue");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("descriptor popped from an empty queue");

	a_accept_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !pop) |=> (credit_q == $past(credit_q) + CNT_W'(1)))
		else $error("accepted request not counted");
`endif

endmodule
